@@ hdl/ihsh_pkg.sv @@
// Shared types, character codes and class codes of the INI/HTML syntax highlighter.
package ihsh_pkg;

   // Highlight classes carried in the result.
   typedef enum logic [2:0] {
      CLS_PLAIN   = 3'd0,
      CLS_SECTION = 3'd1,
      CLS_COMMENT = 3'd2,
      CLS_PROP    = 3'd3,
      CLS_SETTING = 3'd4
   } class_type;

   // Language selection held in the control register.
   typedef enum logic {
      MODE_INI  = 1'b0,
      MODE_HTML = 1'b1
   } mode_type;

   // Character codes the parser looks for.
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_ESC     = 8'd27;
   localparam logic [7:0] CH_QUOTE   = 8'd34;
   localparam logic [7:0] CH_BANG    = 8'd33;
   localparam logic [7:0] CH_DASH    = 8'd45;
   localparam logic [7:0] CH_SEMI    = 8'd59;
   localparam logic [7:0] CH_LT      = 8'd60;
   localparam logic [7:0] CH_EQUAL   = 8'd61;
   localparam logic [7:0] CH_GT      = 8'd62;
   localparam logic [7:0] CH_LBRACK  = 8'd91;
   localparam logic [7:0] CH_NUL     = 8'd0;

   // Parser state kept from one byte to the next.
   typedef struct packed {
      logic [7:0] prev_char;
      class_type  cls;
      logic       bold;
      logic       in_tag;
      logic       in_value;
      logic       unquoted;
      logic       just_opened;
      logic       doctype;
   } hl_state_type;

   // Result of one byte.
   typedef struct packed {
      class_type cls;
      logic      bold;
   } hl_result_type;

   // White space as seen inside tags.
   function automatic logic is_space(input logic [7:0] ch);
      is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
                 (ch == CH_LF) || (ch == CH_ESC);
   endfunction

endpackage

@@ hdl/ini_html_syntax_highlighter.sv @@
// Top level of the INI/HTML syntax highlighter: stream handshake, input and result registers.
//
//   channel  | ports                         | payload
//   ---------+-------------------------------+--------------------------------------
//   request  | req_tvalid/tready/tdata/tuser | tdata[7:0] text_byte, tuser restart
//   response | rsp_tvalid/tready/tdata       | tdata[2:0] color_class, [3] bold
//   control  | csr_wr_en/csr_wr_data         | language_mode, 0 INI, 1 HTML
//
// Every byte passes an input register and a result register, one byte per cycle
// sustained while rsp_tready stays high.
// Synchronous active-high reset clears both stages, the parser state and the mode.
// A stalled response holds its stage; the input stage keeps filling until it is
// also held, then req_tready drops.
module ini_html_syntax_highlighter
   import ihsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tuser,   // [0] restart
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] color_class, [3] bold, [7:4] zero
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic          mode_ff;
   logic          s1_valid_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_restart_ff;
   logic          rsp_valid_ff;
   hl_result_type rsp_result_ff;
   hl_result_type result;
   logic          out_free;
   logic          step;

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INI;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Handshake: each stage moves when the one after it is free.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_byte_ff    <= req_tdata;
         s1_restart_ff <= req_tuser;
      end
   end

   ihsh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (s1_byte_ff),
      .restart   (s1_restart_ff),
      .mode      (mode_type'(mode_ff)),
      .result    (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_result_ff.bold, rsp_result_ff.cls};

`ifndef SYNTHESIS
   // Comment text is never drawn bold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_result_ff.cls == CLS_COMMENT) |-> !rsp_result_ff.bold)
      else $error("bold comment result");

   // A byte held in the input stage is not dropped while the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("input stage lost a byte");

   // Only codes of defined classes leave the block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_result_ff.cls == CLS_PLAIN || rsp_result_ff.cls == CLS_SECTION ||
                        rsp_result_ff.cls == CLS_COMMENT || rsp_result_ff.cls == CLS_PROP ||
                        rsp_result_ff.cls == CLS_SETTING))
      else $error("undefined class code");
`endif

endmodule

@@ hdl/ihsh_core.sv @@
// Parser state registers and the per-byte state update of the highlighter.
module ihsh_core
   import ihsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    text_byte,
   input  logic          restart,
   input  mode_type      mode,
   output hl_result_type result
);

   hl_state_type state_ff;
   hl_state_type state_in;

   // Next state of the parser for the byte at hand.
   always_comb begin
      hl_state_type s;
      logic         done;
      logic         opened;
      logic [7:0]   c;
      logic [7:0]   p;
      s      = state_ff;
      done   = 1'b0;
      opened = 1'b0;
      c      = text_byte;

      // A restart clears the state ahead of the byte; the doctype flag is kept.
      if (restart) begin
         s.cls         = CLS_PLAIN;
         s.bold        = 1'b0;
         s.in_tag      = 1'b0;
         s.in_value    = 1'b0;
         s.unquoted    = 1'b0;
         s.just_opened = 1'b0;
         s.prev_char   = (mode == MODE_INI) ? CH_CR : CH_NUL;
      end
      p = s.prev_char;

      if (mode == MODE_INI) begin
         // The first byte of a line picks the class; the byte after '=' starts a value.
         if (p == CH_CR || p == CH_LF) begin
            if (c == CH_LBRACK) begin
               s.cls  = CLS_SECTION;
               s.bold = 1'b1;
            end else if (c == CH_SEMI) begin
               s.cls  = CLS_COMMENT;
               s.bold = 1'b0;
            end else begin
               s.cls  = CLS_PROP;
               s.bold = 1'b1;
            end
         end else if (p == CH_EQUAL) begin
            s.bold = 1'b0;
            if (s.cls == CLS_PROP) begin
               s.cls = CLS_SETTING;
            end
         end
      end else begin
         // Comments and doctypes run until their closing '>'.
         if (s.cls == CLS_COMMENT) begin
            if (p == CH_BANG && c != CH_GT) begin
               s.doctype = (c != CH_DASH);
            end
            if (c == CH_GT && (s.doctype || p == CH_DASH)) begin
               s.in_tag      = 1'b0;
               s.in_value    = 1'b0;
               s.unquoted    = 1'b0;
               s.cls         = CLS_PLAIN;
               s.bold        = 1'b0;
               s.just_opened = 1'b0;
            end
            done = 1'b1;
         end

         // The byte after a closing quote ends the quoted value.
         if (!done && p == CH_QUOTE && s.in_value && !s.just_opened) begin
            s.cls      = CLS_PLAIN;
            s.bold     = 1'b1;
            s.in_value = 1'b0;
            s.unquoted = 1'b0;
            if (c == CH_GT && s.in_tag) begin
               s.in_tag      = 1'b0;
               s.bold        = 1'b0;
               s.just_opened = 1'b0;
            end
            done = 1'b1;
         end

         // A '>' outside a quoted value closes the tag.
         if (!done && c == CH_GT && s.in_tag && (!s.in_value || s.unquoted)) begin
            s.in_tag      = 1'b0;
            s.in_value    = 1'b0;
            s.unquoted    = 1'b0;
            s.cls         = CLS_PLAIN;
            s.bold        = 1'b0;
            s.just_opened = 1'b0;
            done          = 1'b1;
         end

         if (!done) begin
            // The byte after '<' opens a tag or a comment.
            if (p == CH_LT && !s.in_value) begin
               s.in_tag   = 1'b1;
               s.in_value = 1'b0;
               s.unquoted = 1'b0;
               if (c == CH_BANG) begin
                  s.cls  = CLS_COMMENT;
                  s.bold = 1'b0;
               end else begin
                  s.cls  = CLS_SECTION;
                  s.bold = 1'b1;
               end
            end

            // White space after an unquoted value ends it.
            if (s.in_tag && s.in_value && s.unquoted && is_space(p)) begin
               s.in_value = 1'b0;
               s.unquoted = 1'b0;
               s.cls      = CLS_PLAIN;
               s.bold     = 1'b1;
            end

            // Attribute names, '=' and the start of values inside a tag.
            if (s.in_tag) begin
               if ((!s.in_value || s.unquoted) && is_space(c)) begin
                  s.in_value = 1'b0;
                  s.unquoted = 1'b0;
                  s.cls      = CLS_PLAIN;
                  s.bold     = 1'b1;
               end
               if (!s.in_value && c == CH_EQUAL) begin
                  s.cls  = CLS_PLAIN;
                  s.bold = 1'b0;
               end
               if ((c == CH_QUOTE || p == CH_EQUAL) && !s.in_value) begin
                  s.unquoted    = (c != CH_QUOTE);
                  s.in_value    = 1'b1;
                  s.cls         = CLS_SETTING;
                  s.bold        = 1'b0;
                  s.just_opened = 1'b1;
                  opened        = 1'b1;
               end
            end

            if (!opened) begin
               s.just_opened = 1'b0;
            end
         end
      end

      s.prev_char = c;
      state_in    = s;
   end

   assign result.cls  = state_in.cls;
   assign result.bold = state_in.bold;

   // State advances once for every byte handed over.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{prev_char:   CH_NUL,
                       cls:         CLS_PLAIN,
                       bold:        1'b0,
                       in_tag:      1'b0,
                       in_value:    1'b0,
                       unquoted:    1'b0,
                       just_opened: 1'b1,
                       doctype:     1'b0};
      end else if (step) begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // The stored previous character is the byte of the last step.
   assert property (@(posedge clock) disable iff (reset)
      step |=> (state_ff.prev_char == $past(text_byte)))
      else $error("previous character not taken from last byte");

   // Without a step the parser state stays put.
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff))
      else $error("parser state changed without a byte");

   // A restart in INI mode leaves no tag open.
   assert property (@(posedge clock) disable iff (reset)
      step && restart && (mode == MODE_INI) |=> !state_ff.in_tag)
      else $error("tag left open after an INI restart");
`endif

endmodule
